FILE: rtl/core/adsrg_pkg.sv
// Shared types and constants for the ADSR envelope gain block.
package adsrg_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int LEN_W           = 24;
  localparam int CFG_IDX_W       = 3;
  localparam int SAMPLE_W        = 16;
  localparam int GAIN_W          = 16;
  localparam int PHASE_W         = 3;
  localparam int DIV_Q_W         = 16;
  localparam int DIV_NUM_W       = LEN_W + DIV_Q_W;
  localparam int DIV_CNT_W       = $clog2(DIV_Q_W);
  localparam int COEF_W          = 15;

  localparam logic [GAIN_W-1:0] GAIN_ONE  = 16'd32768;
  localparam logic [GAIN_W-1:0] GAIN_SUS  = 16'd9830;
  localparam logic [GAIN_W-1:0] GAIN_DROP = GAIN_ONE - GAIN_SUS;

  typedef enum logic [PHASE_W-1:0] {
    PH_ATTACK  = 3'd0,
    PH_DECAY   = 3'd1,
    PH_SUSTAIN = 3'd2,
    PH_RELEASE = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_SUSTAIN = 3'd2,
    REG_RELEASE = 3'd3,
    REG_TOTAL   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0] attack_len;
    logic [LEN_W-1:0] decay_len;
    logic [LEN_W-1:0] sustain_len;
    logic [LEN_W-1:0] release_len;
    logic [LEN_W-1:0] total_len;
  } cfg_regs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

FILE: rtl/core/adsrg_if.sv
// Channel interfaces: sample input, result output and register write.
interface adsrg_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [adsrg_pkg::SAMPLE_W-1:0] sample_in;
  logic                                 restart;
  modport source (output valid, sample_in, restart, input ready);
  modport sink   (input valid, sample_in, restart, output ready);
endinterface

interface adsrg_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [adsrg_pkg::SAMPLE_W-1:0] sample_out;
  logic [adsrg_pkg::GAIN_W-1:0]          gain;
  logic [adsrg_pkg::PHASE_W-1:0]         phase;
  modport source (output valid, sample_out, gain, phase, input ready);
  modport sink   (input valid, sample_out, gain, phase, output ready);
endinterface

interface adsrg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [adsrg_pkg::CFG_IDX_W-1:0] index;
  logic [adsrg_pkg::LEN_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/adsrg_cfg.sv
// Phase length register file with write decode.
module adsrg_cfg (
  input  logic                 clk,
  input  logic                 rst,
  adsrg_cfg_if.sink            cfg,
  output adsrg_pkg::cfg_regs_t regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (adsrg_pkg::reg_idx_t'(cfg.index))
        adsrg_pkg::REG_ATTACK:  regs.attack_len  <= cfg.data;
        adsrg_pkg::REG_DECAY:   regs.decay_len   <= cfg.data;
        adsrg_pkg::REG_SUSTAIN: regs.sustain_len <= cfg.data;
        adsrg_pkg::REG_RELEASE: regs.release_len <= cfg.data;
        adsrg_pkg::REG_TOTAL:   regs.total_len   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/core/adsrg_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit DIV_Q_W bits.
module adsrg_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [adsrg_pkg::DIV_NUM_W-1:0]     num,
  input  logic [adsrg_pkg::LEN_W-1:0]         den,
  output adsrg_pkg::div_status_t              stat,
  output logic [adsrg_pkg::DIV_Q_W-1:0]       quot
);

  logic [adsrg_pkg::LEN_W-1:0]     rem;
  logic [adsrg_pkg::LEN_W-1:0]     den_q;
  logic [adsrg_pkg::DIV_Q_W-1:0]   low;
  logic [adsrg_pkg::DIV_CNT_W-1:0] cnt;
  logic [adsrg_pkg::LEN_W:0]       trial;
  logic [adsrg_pkg::LEN_W:0]       diff;
  logic                            fits;

  assign trial = {rem, low[adsrg_pkg::DIV_Q_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        rem       <= num[adsrg_pkg::DIV_NUM_W-1 -: adsrg_pkg::LEN_W];
        low       <= num[adsrg_pkg::DIV_Q_W-1:0];
        den_q     <= den;
        cnt       <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        rem  <= fits ? diff[adsrg_pkg::LEN_W-1:0] : trial[adsrg_pkg::LEN_W-1:0];
        low  <= {low[adsrg_pkg::DIV_Q_W-2:0], 1'b0};
        quot <= {quot[adsrg_pkg::DIV_Q_W-2:0], fits};
        cnt  <= cnt + 1'b1;
        if (cnt == {adsrg_pkg::DIV_CNT_W{1'b1}}) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/adsr_envelope_gain_top.sv
// ADSR envelope gain: one sample at a time, a 16-bit input sample is scaled by a
// piecewise-linear attack/decay/sustain/release gain in unsigned Q1.15 taken at the
// current sample position, which then advances by one and saturates at its top.
// A sample inside the attack, decay or release ramp passes through the sum, classify,
// setup, divide, apply and output steps, its time set mostly by the 16-step restoring
// divider that forms the ramp fraction; sustain, zero release, release past its length
// and done samples skip the divide step.
// Input ready is high only while the sequencer is idle; a result still waiting at the
// output holds the sequencer in its last step until that result is taken.
// Length registers may be written whenever no sample is in flight.
module adsr_envelope_gain_top #(
  parameter int COUNT_WIDTH = adsrg_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  adsrg_sample_if.sink    samples,
  adsrg_result_if.source  results,
  adsrg_cfg_if.sink       cfg
);

  localparam int SW = ((COUNT_WIDTH > adsrg_pkg::LEN_W) ? COUNT_WIDTH : adsrg_pkg::LEN_W) + 2;
  localparam int PROD_W = adsrg_pkg::SAMPLE_W + adsrg_pkg::GAIN_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM1, ST_SUM2, ST_CLASS, ST_SETUP, ST_DIV, ST_APPLY, ST_OUT
  } state_t;

  adsrg_pkg::cfg_regs_t    regs;
  adsrg_pkg::div_status_t  div_stat;
  logic [adsrg_pkg::DIV_Q_W-1:0] quot;

  state_t                              state;
  logic [COUNT_WIDTH-1:0]              position;
  logic [COUNT_WIDTH-1:0]              pos_cur;
  logic [SW-1:0]                       p_ext;
  logic [SW-1:0]                       d_end;
  logic [SW-1:0]                       s_end;
  logic [SW-1:0]                       off;
  logic signed [adsrg_pkg::SAMPLE_W-1:0] smp;
  adsrg_pkg::phase_t                   phase;
  logic [adsrg_pkg::GAIN_W-1:0]        gain;
  logic [adsrg_pkg::DIV_NUM_W-1:0]     num;
  logic [adsrg_pkg::LEN_W-1:0]         den;
  logic                                div_start;
  logic [adsrg_pkg::COEF_W-1:0]        coef;
  logic [adsrg_pkg::LEN_W+adsrg_pkg::COEF_W-1:0] mul;
  logic signed [PROD_W-1:0]            prod;
  logic                                out_valid;
  logic signed [adsrg_pkg::SAMPLE_W-1:0] out_sample;
  logic [adsrg_pkg::GAIN_W-1:0]        out_gain;
  logic [adsrg_pkg::PHASE_W-1:0]       out_phase;

  adsrg_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  adsrg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .stat  (div_stat),
    .quot  (quot)
  );

  assign samples.ready      = (state == ST_IDLE);
  assign results.valid      = out_valid;
  assign results.sample_out = out_sample;
  assign results.gain       = out_gain;
  assign results.phase      = out_phase;

  assign pos_cur = samples.restart ? '0 : position;
  assign coef = (phase == adsrg_pkg::PH_DECAY) ?
                adsrg_pkg::GAIN_DROP[adsrg_pkg::COEF_W-1:0] :
                adsrg_pkg::GAIN_SUS[adsrg_pkg::COEF_W-1:0];
  assign mul  = off[adsrg_pkg::LEN_W-1:0] * coef;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      position  <= '0;
      div_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && results.ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (samples.valid) begin
            p_ext    <= SW'(pos_cur);
            smp      <= samples.sample_in;
            position <= (pos_cur == {COUNT_WIDTH{1'b1}}) ? pos_cur : pos_cur + 1'b1;
            state    <= ST_SUM1;
          end
        end
        ST_SUM1: begin
          d_end <= SW'(regs.attack_len) + SW'(regs.decay_len);
          state <= ST_SUM2;
        end
        ST_SUM2: begin
          s_end <= d_end + SW'(regs.sustain_len);
          state <= ST_CLASS;
        end
        ST_CLASS: begin
          if (p_ext >= SW'(regs.total_len)) begin
            phase <= adsrg_pkg::PH_DONE;
          end else if (p_ext < SW'(regs.attack_len)) begin
            phase <= adsrg_pkg::PH_ATTACK;
          end else if (p_ext < d_end) begin
            phase <= adsrg_pkg::PH_DECAY;
            off   <= p_ext - SW'(regs.attack_len);
          end else if (p_ext < s_end) begin
            phase <= adsrg_pkg::PH_SUSTAIN;
          end else begin
            phase <= adsrg_pkg::PH_RELEASE;
            off   <= p_ext - s_end;
          end
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          case (phase)
            adsrg_pkg::PH_ATTACK: begin
              num       <= {1'b0, p_ext[adsrg_pkg::LEN_W-1:0], {adsrg_pkg::COEF_W{1'b0}}};
              den       <= regs.attack_len;
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
            adsrg_pkg::PH_DECAY: begin
              num       <= {1'b0, mul};
              den       <= regs.decay_len;
              div_start <= 1'b1;
              state     <= ST_DIV;
            end
            adsrg_pkg::PH_SUSTAIN: begin
              gain  <= adsrg_pkg::GAIN_SUS;
              state <= ST_APPLY;
            end
            adsrg_pkg::PH_RELEASE: begin
              if (off >= SW'(regs.release_len)) begin
                gain  <= '0;
                state <= ST_APPLY;
              end else begin
                num       <= {1'b0, mul};
                den       <= regs.release_len;
                div_start <= 1'b1;
                state     <= ST_DIV;
              end
            end
            default: begin
              gain  <= '0;
              state <= ST_APPLY;
            end
          endcase
        end
        ST_DIV: begin
          if (div_stat.done) begin
            case (phase)
              adsrg_pkg::PH_DECAY:   gain <= adsrg_pkg::GAIN_ONE - quot;
              adsrg_pkg::PH_RELEASE: gain <= adsrg_pkg::GAIN_SUS - quot;
              default:               gain <= quot;
            endcase
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          prod  <= PROD_W'(smp) * PROD_W'(signed'({1'b0, gain}));
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || results.ready) begin
            out_sample <= prod[adsrg_pkg::SAMPLE_W+14:15];
            out_gain   <= gain;
            out_phase  <= phase;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> state == ST_DIV)
    else $error("divider running outside divide step");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.gain <= adsrg_pkg::GAIN_ONE)
    else $error("gain above unity");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.phase == adsrg_pkg::PH_DONE |->
      results.gain == '0 && results.sample_out == '0)
    else $error("done phase with nonzero output");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("second sample taken while busy");

endmodule

FILE: sim/tb_adsr_envelope_gain_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for adsr_envelope_gain_top: directed walks, backpressure, random envelopes.
module tb_adsr_envelope_gain_top;

  localparam int RANDOM_ITEMS     = 900;
  localparam int MAX_SEQ_ITEMS    = 48;
  localparam int SINK_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES     = 40;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int REPORT_LIMIT     = 50;
  localparam int SW               = adsrg_pkg::SAMPLE_W;
  localparam int GW               = adsrg_pkg::GAIN_W;
  localparam int LW               = adsrg_pkg::LEN_W;
  localparam logic [LW-1:0] LEN_MAX = '1;

  typedef struct {
    logic signed [SW-1:0] sample_out;
    logic [GW-1:0]        gain;
    adsrg_pkg::phase_t    phase;
  } envelope_beat_t;

  logic clk;
  logic rst;

  adsrg_sample_if sample_bus();
  adsrg_result_if result_bus();
  adsrg_cfg_if    cfg_bus();

  adsr_envelope_gain_top dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  adsrg_pkg::cfg_regs_t                   env_regs;
  logic [adsrg_pkg::COUNT_WIDTH_DEF-1:0]  env_position;
  envelope_beat_t                         expected_beats[$];

  int error_count;
  int beats_checked;
  int samples_sent;
  int envelopes_loaded;
  int cycle_count;
  int phase_hits[int'(adsrg_pkg::PH_DONE)+1];

  bit sender_quiet;
  bit sink_quiet;
  bit hold_req;
  bit sink_held;
  int sink_stall;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int idle_span(input bit quiet);
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 15))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return 16'sh0000;
      3:       return 16'shFFFF;
      default: return SW'($urandom);
    endcase
  endfunction

  // gain at the current position, then advance the position (saturating)
  function automatic envelope_beat_t predict_beat(input logic signed [SW-1:0] value,
                                                  input bit restart_pos);
    longint unsigned p, a_end, d_end, s_end, k;
    longint          prod;
    envelope_beat_t  b;
    if (restart_pos) env_position = '0;
    p     = env_position;
    a_end = env_regs.attack_len;
    d_end = a_end + env_regs.decay_len;
    s_end = d_end + env_regs.sustain_len;
    if (p >= env_regs.total_len) begin
      b.gain  = '0;
      b.phase = adsrg_pkg::PH_DONE;
    end else if (p < a_end) begin
      b.gain  = GW'((p * adsrg_pkg::GAIN_ONE) / a_end);
      b.phase = adsrg_pkg::PH_ATTACK;
    end else if (p < d_end) begin
      b.gain  = adsrg_pkg::GAIN_ONE -
                GW'(((p - a_end) * adsrg_pkg::GAIN_DROP) / env_regs.decay_len);
      b.phase = adsrg_pkg::PH_DECAY;
    end else if (p < s_end) begin
      b.gain  = adsrg_pkg::GAIN_SUS;
      b.phase = adsrg_pkg::PH_SUSTAIN;
    end else begin
      k = p - s_end;
      if (env_regs.release_len == '0 || k >= env_regs.release_len) begin
        b.gain = '0;
      end else begin
        b.gain = adsrg_pkg::GAIN_SUS -
                 GW'((k * adsrg_pkg::GAIN_SUS) / env_regs.release_len);
      end
      b.phase = adsrg_pkg::PH_RELEASE;
    end
    prod         = longint'(value) * longint'(b.gain);
    b.sample_out = SW'(prod >>> 15);
    if (env_position != '1) env_position++;
    return b;
  endfunction

  task automatic report_error(input string what);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR result %0d: %s", beats_checked, what);
  endtask

  task automatic send_sample(input logic signed [SW-1:0] value, input bit restart_pos);
    int gap;
    gap = idle_span(sender_quiet);
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid     <= 1'b1;
    sample_bus.sample_in <= value;
    sample_bus.restart   <= restart_pos;
    do @(posedge clk); while (!sample_bus.ready);
    expected_beats.insert(expected_beats.size(), predict_beat(value, restart_pos));
    samples_sent++;
  endtask

  // leaves cfg valid high; caller drops it once the last beat is through
  task automatic write_reg(input logic [adsrg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [LW-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      adsrg_pkg::REG_ATTACK:  env_regs.attack_len  = value;
      adsrg_pkg::REG_DECAY:   env_regs.decay_len   = value;
      adsrg_pkg::REG_SUSTAIN: env_regs.sustain_len = value;
      adsrg_pkg::REG_RELEASE: env_regs.release_len = value;
      adsrg_pkg::REG_TOTAL:   env_regs.total_len   = value;
      default: ;
    endcase
  endtask

  task automatic settle();
    sample_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic load_envelope(input logic [LW-1:0] a, d, s, r, t);
    settle();
    write_reg(adsrg_pkg::REG_ATTACK, a);
    write_reg(adsrg_pkg::REG_DECAY, d);
    write_reg(adsrg_pkg::REG_SUSTAIN, s);
    write_reg(adsrg_pkg::REG_RELEASE, r);
    write_reg(adsrg_pkg::REG_TOTAL, t);
    cfg_bus.valid <= 1'b0;
    envelopes_loaded++;
  endtask

  task automatic test_reset_defaults();
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh0000, 1'b0);
  endtask

  // one sample per step: attack, two decay, sustain, two release, two release past its end, done
  task automatic test_phase_walk();
    load_envelope(1, 2, 1, 2, 8);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh3039, 1'b0);
  endtask

  // skipped phases, zero release length, writes to unmapped indexes must not land
  task automatic test_zero_lengths_unmapped();
    load_envelope(0, 0, 0, 0, 3);
    settle();
    for (int i = int'(adsrg_pkg::REG_TOTAL) + 1; i < (1 << adsrg_pkg::CFG_IDX_W); i++) begin
      write_reg(adsrg_pkg::CFG_IDX_W'(i), LEN_MAX);
    end
    cfg_bus.valid <= 1'b0;
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh4000, 1'b0);
    send_sample(16'shFFFF, 1'b0);
  endtask

  task automatic test_long_lengths();
    load_envelope(LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX, LEN_MAX);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh5A5A, 1'b0);
  endtask

  task automatic test_sink_backpressure();
    load_envelope(3, 3, 2, 4, 14);
    sender_quiet = 1'b1;
    sink_quiet   = 1'b1;
    hold_req     = 1'b1;
    send_sample(rand_sample(), 1'b1);
    repeat (15) send_sample(rand_sample(), 1'b0);
    settle();
  endtask

  task automatic test_random_envelopes();
    logic [LW-1:0] lens[int'(adsrg_pkg::REG_TOTAL)+1];
    int  mode, sum, seq_count, seq_len, random_sent;
    bit  lead_restart;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      sum  = 0;
      for (int i = 0; i < int'(adsrg_pkg::REG_TOTAL); i++) begin
        if (mode == 7) lens[i] = LW'($urandom);
        else if (mode == 8)
          lens[i] = ($urandom_range(0, 2) == 0) ? LEN_MAX : LW'($urandom_range(0, 1));
        else lens[i] = ($urandom_range(0, 4) == 0) ? '0 : LW'($urandom_range(1, 10));
        sum += int'(lens[i]);
      end
      if (mode == 7) lens[adsrg_pkg::REG_TOTAL] = LW'($urandom);
      else if (mode == 8)
        lens[adsrg_pkg::REG_TOTAL] = ($urandom_range(0, 1) == 0) ? LEN_MAX : '0;
      else if (mode == 9) lens[adsrg_pkg::REG_TOTAL] = LEN_MAX;
      else if ($urandom_range(0, 3) != 0)
        lens[adsrg_pkg::REG_TOTAL] = LW'(sum + $urandom_range(0, 6));
      else lens[adsrg_pkg::REG_TOTAL] = LW'($urandom_range(0, sum));

      sender_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 3) == 0);
      load_envelope(lens[adsrg_pkg::REG_ATTACK], lens[adsrg_pkg::REG_DECAY],
                    lens[adsrg_pkg::REG_SUSTAIN], lens[adsrg_pkg::REG_RELEASE],
                    lens[adsrg_pkg::REG_TOTAL]);

      seq_count = $urandom_range(1, 3);
      for (int s = 0; s < seq_count; s++) begin
        seq_len = (lens[adsrg_pkg::REG_TOTAL] < MAX_SEQ_ITEMS) ?
                  int'(lens[adsrg_pkg::REG_TOTAL]) + $urandom_range(1, 6) : MAX_SEQ_ITEMS;
        lead_restart = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < seq_len; k++) begin
          send_sample(rand_sample(),
                      (k == 0) ? lead_restart : bit'($urandom_range(0, 29) == 0));
          random_sent++;
        end
      end
    end
  endtask

  initial begin
    wait (hold_req);
    @(posedge clk);
    sink_held <= 1'b1;
    repeat (SINK_HOLD_CYCLES) @(posedge clk);
    sink_held <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || sink_held) begin
      result_bus.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      result_bus.ready <= 1'b0;
      sink_stall       <= sink_stall - 1;
    end else begin
      result_bus.ready <= 1'b1;
      sink_stall       <= idle_span(sink_quiet);
    end
  end

  always @(posedge clk) begin
    envelope_beat_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_error("result beat with nothing outstanding");
      end else begin
        want = expected_beats.pop_front();
        phase_hits[want.phase]++;
        if (result_bus.sample_out !== want.sample_out)
          report_error($sformatf("sample_out got %0d want %0d",
                                 result_bus.sample_out, want.sample_out));
        if (result_bus.gain !== want.gain)
          report_error($sformatf("gain got %0d want %0d", result_bus.gain, want.gain));
        if (result_bus.phase !== want.phase)
          report_error($sformatf("phase got %0d want %0d", result_bus.phase, want.phase));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_beats.size());
      $display("adsr_envelope_gain_top: mismatch");
      $finish;
    end
  end

  initial begin
    rst                  <= 1'b1;
    sample_bus.valid     <= 1'b0;
    sample_bus.sample_in <= '0;
    sample_bus.restart   <= 1'b0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.index        <= '0;
    cfg_bus.data         <= '0;
    env_regs     = '0;
    env_position = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_phase_walk();
    test_zero_lengths_unmapped();
    test_long_lengths();
    test_sink_backpressure();
    test_random_envelopes();

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples over %0d envelope settings, %0d results checked",
             samples_sent, envelopes_loaded, beats_checked);
    $display("phases seen: attack %0d decay %0d sustain %0d release %0d done %0d",
             phase_hits[adsrg_pkg::PH_ATTACK], phase_hits[adsrg_pkg::PH_DECAY],
             phase_hits[adsrg_pkg::PH_SUSTAIN], phase_hits[adsrg_pkg::PH_RELEASE],
             phase_hits[adsrg_pkg::PH_DONE]);
    if (error_count == 0) begin
      $display("adsr_envelope_gain_top: match");
    end else begin
      $display("adsr_envelope_gain_top: mismatch");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/adsrg_pkg.sv
rtl/core/adsrg_if.sv
rtl/core/adsrg_cfg.sv
rtl/core/adsrg_div.sv
rtl/core/adsr_envelope_gain_top.sv
sim/tb_adsr_envelope_gain_top.sv
